// ===== rtl/sshes_pkg.sv =====
package sshes_pkg;

    localparam int STRIPS_DEF = 32;

    localparam int STRIP_W  = 5;
    localparam int ADC_W    = 14;
    localparam int OFFSET_W = 12;
    localparam int SLOPE_W  = 6;
    localparam int PAIRS_W  = 11;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 14;

    localparam logic [ADC_W-1:0]    ADC_LIMIT_RST   = 14'd4095;
    localparam logic [OFFSET_W-1:0] BAND_OFFSET_RST = 12'd300;
    localparam logic [SLOPE_W-1:0]  BAND_SLOPE_RST  = 6'd12;

    // slope is held in tenths, so both sides of the band test scale by ten
    localparam int BAND_SCALE = 10;
    localparam int BAND_W     = 21;

    localparam logic MODE_SAMPLE    = 1'b0;
    localparam logic MODE_THRESHOLD = 1'b1;
    localparam logic SIDE_FRONT     = 1'b0;
    localparam logic SIDE_BACK      = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ADC_LIMIT   = 2'd0,
        CFG_BAND_OFFSET = 2'd1,
        CFG_BAND_SLOPE  = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic [ADC_W-1:0]    adc_limit;
        logic [OFFSET_W-1:0] band_offset;
        logic [SLOPE_W-1:0]  band_slope;
    } cfg_t;

endpackage

// ===== rtl/sshes_thr_mem.sv =====
module sshes_thr_mem #(
    parameter int STRIPS = sshes_pkg::STRIPS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         wr_en,
    input  logic                         rd_en,
    input  logic                         side,
    input  logic [$clog2(STRIPS)-1:0]    strip_idx,
    input  logic [sshes_pkg::ADC_W-1:0]  wdata,
    output logic [sshes_pkg::ADC_W-1:0]  rdata
);

    localparam int SW    = $clog2(STRIPS);
    localparam int AW    = SW + 1;
    localparam int DEPTH = 2 ** AW;

    logic [sshes_pkg::ADC_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]            valid_reg;
    logic [sshes_pkg::ADC_W-1:0] rdata_reg;
    logic [AW-1:0]               addr;

    assign addr  = {side, strip_idx};
    assign rdata = rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr] <= wdata;
        end
        // an entry never written reads as zero
        if (rd_en)
        begin
            rdata_reg <= valid_reg[addr] ? mem[addr] : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[addr] <= 1'b1;
        end
    end

endmodule

// ===== rtl/sshes_accum.sv =====
module sshes_accum #(
    parameter int STRIPS = sshes_pkg::STRIPS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           load,
    input  logic                           side,
    input  logic [sshes_pkg::STRIP_W-1:0]  strip,
    input  logic [sshes_pkg::ADC_W-1:0]    value,
    input  logic                           last,
    input  logic                           in_range,
    input  logic [sshes_pkg::ADC_W-1:0]    thr,
    input  logic                           sum_ready,
    output logic                           s1_free,
    output logic                           sum_valid,
    output logic [$clog2(STRIPS+1)-1:0]    sum_f_cnt,
    output logic [$clog2(STRIPS+1)-1:0]    sum_b_cnt,
    output logic [sshes_pkg::STRIP_W-1:0]  sum_f_strip,
    output logic [sshes_pkg::STRIP_W-1:0]  sum_b_strip,
    output logic [sshes_pkg::ADC_W-1:0]    sum_f_adc,
    output logic [sshes_pkg::ADC_W-1:0]    sum_b_adc
);

    localparam int CW = $clog2(STRIPS + 1);

    logic                          s1_valid_reg;
    logic                          s1_side_reg;
    logic [sshes_pkg::STRIP_W-1:0] s1_strip_reg;
    logic [sshes_pkg::ADC_W-1:0]   s1_value_reg;
    logic                          s1_last_reg;
    logic                          s1_in_range_reg;

    logic [CW-1:0]                 f_cnt_reg,   f_cnt_next;
    logic [CW-1:0]                 b_cnt_reg,   b_cnt_next;
    logic [sshes_pkg::STRIP_W-1:0] f_strip_reg, f_strip_next;
    logic [sshes_pkg::STRIP_W-1:0] b_strip_reg, b_strip_next;
    logic [sshes_pkg::ADC_W-1:0]   f_adc_reg,   f_adc_next;
    logic [sshes_pkg::ADC_W-1:0]   b_adc_reg,   b_adc_next;

    logic hit, f_upd, b_upd, f_take, b_take, s1_done;

    assign s1_done   = s1_valid_reg && (!s1_last_reg || sum_ready);
    assign s1_free   = !s1_valid_reg || s1_done;
    assign sum_valid = s1_valid_reg && s1_last_reg;

    always_comb
    begin
        hit    = s1_in_range_reg && (s1_value_reg > thr);
        f_upd  = hit && (s1_side_reg == sshes_pkg::SIDE_FRONT);
        b_upd  = hit && (s1_side_reg == sshes_pkg::SIDE_BACK);
        // later sample wins a tie on the highest strip
        f_take = f_upd && ((f_cnt_reg == '0) || (s1_strip_reg >= f_strip_reg));
        b_take = b_upd && ((b_cnt_reg == '0) || (s1_strip_reg >= b_strip_reg));

        f_cnt_next = f_cnt_reg;
        if (f_upd && (f_cnt_reg < CW'(STRIPS)))
        begin
            f_cnt_next = f_cnt_reg + CW'(1);
        end
        b_cnt_next = b_cnt_reg;
        if (b_upd && (b_cnt_reg < CW'(STRIPS)))
        begin
            b_cnt_next = b_cnt_reg + CW'(1);
        end

        f_strip_next = f_take ? s1_strip_reg : f_strip_reg;
        f_adc_next   = f_take ? s1_value_reg : f_adc_reg;
        b_strip_next = b_take ? s1_strip_reg : b_strip_reg;
        b_adc_next   = b_take ? s1_value_reg : b_adc_reg;
    end

    assign sum_f_cnt   = f_cnt_next;
    assign sum_b_cnt   = b_cnt_next;
    assign sum_f_strip = f_strip_next;
    assign sum_b_strip = b_strip_next;
    assign sum_f_adc   = f_adc_next;
    assign sum_b_adc   = b_adc_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_free)
        begin
            s1_valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            s1_side_reg     <= side;
            s1_strip_reg    <= strip;
            s1_value_reg    <= value;
            s1_last_reg     <= last;
            s1_in_range_reg <= in_range;
        end
    end

    // clear the event once its summary has moved on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_cnt_reg   <= '0;
            b_cnt_reg   <= '0;
            f_strip_reg <= '0;
            b_strip_reg <= '0;
            f_adc_reg   <= '0;
            b_adc_reg   <= '0;
        end
        else if (s1_done)
        begin
            if (s1_last_reg)
            begin
                f_cnt_reg   <= '0;
                b_cnt_reg   <= '0;
                f_strip_reg <= '0;
                b_strip_reg <= '0;
                f_adc_reg   <= '0;
                b_adc_reg   <= '0;
            end
            else
            begin
                f_cnt_reg   <= f_cnt_next;
                b_cnt_reg   <= b_cnt_next;
                f_strip_reg <= f_strip_next;
                b_strip_reg <= b_strip_next;
                f_adc_reg   <= f_adc_next;
                b_adc_reg   <= b_adc_next;
            end
        end
    end

`ifndef SYNTH
    a_event_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_done && s1_last_reg) |=> (f_cnt_reg == '0 && b_cnt_reg == '0))
        else $error("event state not cleared after last sample");

    a_count_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        (f_cnt_reg <= CW'(STRIPS)) && (b_cnt_reg <= CW'(STRIPS)))
        else $error("hit count beyond strip count");

    a_last_held: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_last_reg && !sum_ready) |=> (s1_valid_reg && s1_last_reg))
        else $error("last sample dropped while summary stage was full");
`endif

endmodule

// ===== rtl/sshes_qual.sv =====
module sshes_qual #(
    parameter int STRIPS = sshes_pkg::STRIPS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  sshes_pkg::cfg_t                 cfg,
    input  logic                            sum_valid,
    input  logic [$clog2(STRIPS+1)-1:0]     sum_f_cnt,
    input  logic [$clog2(STRIPS+1)-1:0]     sum_b_cnt,
    input  logic [sshes_pkg::STRIP_W-1:0]   sum_f_strip,
    input  logic [sshes_pkg::STRIP_W-1:0]   sum_b_strip,
    input  logic [sshes_pkg::ADC_W-1:0]     sum_f_adc,
    input  logic [sshes_pkg::ADC_W-1:0]     sum_b_adc,
    output logic                            sum_ready,
    input  logic                            out_stall,
    output logic                            out_valid,
    output logic [sshes_pkg::PAIRS_W-1:0]   hit_pairs,
    output logic [sshes_pkg::STRIP_W-1:0]   front_strip,
    output logic [sshes_pkg::STRIP_W-1:0]   back_strip,
    output logic [sshes_pkg::ADC_W-1:0]     front_adc,
    output logic [sshes_pkg::ADC_W-1:0]     back_adc,
    output logic                            single_hit,
    output logic                            accepted
);

    localparam int CW = $clog2(STRIPS + 1);
    localparam int PW = 2 * CW + sshes_pkg::PAIRS_W;
    localparam int BW = sshes_pkg::BAND_W;

    logic                          s2_valid_reg;
    logic [CW-1:0]                 s2_f_cnt_reg, s2_b_cnt_reg;
    logic [sshes_pkg::STRIP_W-1:0] s2_f_strip_reg, s2_b_strip_reg;
    logic [sshes_pkg::ADC_W-1:0]   s2_f_adc_reg, s2_b_adc_reg;

    logic                          out_valid_reg;
    logic [sshes_pkg::PAIRS_W-1:0] hit_pairs_reg;
    logic [sshes_pkg::STRIP_W-1:0] front_strip_reg, back_strip_reg;
    logic [sshes_pkg::ADC_W-1:0]   front_adc_reg, back_adc_reg;
    logic                          single_hit_reg, accepted_reg;

    logic          out_free, s2_free;
    logic [PW-1:0] pairs_wide;
    logic          single;
    logic [BW-1:0] x_scaled, y_scaled, x_band, y_band, off_scaled;
    logic          in_limit, in_band;

    assign out_free  = !out_valid_reg || !out_stall;
    assign s2_free   = !s2_valid_reg || out_free;
    assign sum_ready = s2_free;

    always_comb
    begin
        pairs_wide = PW'(s2_f_cnt_reg) * PW'(s2_b_cnt_reg);
        single     = (pairs_wide == PW'(1));

        off_scaled = BW'(cfg.band_offset) * BW'(sshes_pkg::BAND_SCALE);
        x_scaled   = BW'(s2_f_adc_reg) * BW'(sshes_pkg::BAND_SCALE);
        y_scaled   = BW'(s2_b_adc_reg) * BW'(sshes_pkg::BAND_SCALE);
        x_band     = BW'(cfg.band_slope) * BW'(s2_f_adc_reg) + off_scaled;
        y_band     = BW'(cfg.band_slope) * BW'(s2_b_adc_reg) + off_scaled;

        in_limit = (s2_f_adc_reg <= cfg.adc_limit) && (s2_b_adc_reg <= cfg.adc_limit);
        // back against front band edge, then front against back
        in_band  = (y_scaled <= x_band) && (x_scaled <= y_band);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s2_free)
            begin
                s2_valid_reg <= sum_valid;
            end
            if (out_free)
            begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_free && sum_valid)
        begin
            s2_f_cnt_reg   <= sum_f_cnt;
            s2_b_cnt_reg   <= sum_b_cnt;
            s2_f_strip_reg <= sum_f_strip;
            s2_b_strip_reg <= sum_b_strip;
            s2_f_adc_reg   <= sum_f_adc;
            s2_b_adc_reg   <= sum_b_adc;
        end
        if (out_free && s2_valid_reg)
        begin
            hit_pairs_reg   <= pairs_wide[sshes_pkg::PAIRS_W-1:0];
            front_strip_reg <= s2_f_strip_reg;
            back_strip_reg  <= s2_b_strip_reg;
            front_adc_reg   <= s2_f_adc_reg;
            back_adc_reg    <= s2_b_adc_reg;
            single_hit_reg  <= single;
            accepted_reg    <= single && in_limit && in_band;
        end
    end

    assign out_valid   = out_valid_reg;
    assign hit_pairs   = hit_pairs_reg;
    assign front_strip = front_strip_reg;
    assign back_strip  = back_strip_reg;
    assign front_adc   = front_adc_reg;
    assign back_adc    = back_adc_reg;
    assign single_hit  = single_hit_reg;
    assign accepted    = accepted_reg;

`ifndef SYNTH
    a_accept_needs_single: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && accepted_reg) |-> single_hit_reg)
        else $error("accepted event without a single hit");

    a_summary_held: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && !out_free) |=> s2_valid_reg)
        else $error("summary lost while result was stalled");
`endif

endmodule

// ===== rtl/strip_single_hit_event_select.sv =====
// Single-hit event qualifier for a double-sided strip detector.
// Input channel (in_valid / in_stall): one item per transfer. mode selects a
// threshold write (value stored for the strip on that side) or an ADC sample;
// a sample above its strip threshold is a hit. last on a sample closes the
// event and produces one result; other items produce none.
// Output channel (out_valid / out_stall): hit pair count, highest hit strip
// and its ADC value per side, single-hit flag and the limit/band verdict.
// Configuration (cfg_valid / cfg_ready): index 0 ADC limit, 1 band offset,
// 2 band slope in tenths; cfg_ready is always high. Write only while idle.
// Throughput: one item per cycle while in_stall is low. The threshold read
// from the table memory is registered with the sample (stage s1), the
// accumulate into stage s2, the final multiply and band test into the output.
// When out_stall is held the three stages fill, then in_stall rises;
// samples that close no event keep flowing while only the result waits.
// Reset clears the event state, all thresholds to zero (valid bit per table
// entry) and loads the register defaults; no clearing pass is needed.
module strip_single_hit_event_select #(
    parameter int STRIPS = sshes_pkg::STRIPS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [sshes_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sshes_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              mode,
    input  logic                              side,
    input  logic [sshes_pkg::STRIP_W-1:0]     strip,
    input  logic [sshes_pkg::ADC_W-1:0]       value,
    input  logic                              last,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [sshes_pkg::PAIRS_W-1:0]     hit_pairs,
    output logic [sshes_pkg::STRIP_W-1:0]     front_strip,
    output logic [sshes_pkg::STRIP_W-1:0]     back_strip,
    output logic [sshes_pkg::ADC_W-1:0]       front_adc,
    output logic [sshes_pkg::ADC_W-1:0]       back_adc,
    output logic                              single_hit,
    output logic                              accepted
);

    localparam int SW = $clog2(STRIPS);
    localparam int EW = sshes_pkg::STRIP_W + SW;
    localparam int CW = $clog2(STRIPS + 1);

    sshes_pkg::cfg_t cfg_reg;

    logic                          accept, in_range, s1_free;
    logic [EW-1:0]                 strip_ext;
    logic [SW-1:0]                 strip_idx;
    logic [sshes_pkg::ADC_W-1:0]   thr;

    logic                          sum_valid, sum_ready;
    logic [CW-1:0]                 sum_f_cnt, sum_b_cnt;
    logic [sshes_pkg::STRIP_W-1:0] sum_f_strip, sum_b_strip;
    logic [sshes_pkg::ADC_W-1:0]   sum_f_adc, sum_b_adc;

    assign cfg_ready = 1'b1;
    assign in_stall  = !s1_free;
    assign accept    = in_valid && !in_stall;

    // strips at or beyond the strip count are ignored
    assign strip_ext = {{SW{1'b0}}, strip};
    assign in_range  = strip_ext < EW'(STRIPS);
    assign strip_idx = strip_ext[SW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.adc_limit   <= sshes_pkg::ADC_LIMIT_RST;
            cfg_reg.band_offset <= sshes_pkg::BAND_OFFSET_RST;
            cfg_reg.band_slope  <= sshes_pkg::BAND_SLOPE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                sshes_pkg::CFG_ADC_LIMIT:
                    cfg_reg.adc_limit <= cfg_data[sshes_pkg::ADC_W-1:0];
                sshes_pkg::CFG_BAND_OFFSET:
                    cfg_reg.band_offset <= cfg_data[sshes_pkg::OFFSET_W-1:0];
                sshes_pkg::CFG_BAND_SLOPE:
                    cfg_reg.band_slope <= cfg_data[sshes_pkg::SLOPE_W-1:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    sshes_thr_mem #(
        .STRIPS (STRIPS)
    ) u_thr_mem (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (accept && (mode == sshes_pkg::MODE_THRESHOLD) && in_range),
        .rd_en     (accept && (mode == sshes_pkg::MODE_SAMPLE)),
        .side      (side),
        .strip_idx (strip_idx),
        .wdata     (value),
        .rdata     (thr)
    );

    sshes_accum #(
        .STRIPS (STRIPS)
    ) u_accum (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (accept && (mode == sshes_pkg::MODE_SAMPLE)),
        .side        (side),
        .strip       (strip),
        .value       (value),
        .last        (last),
        .in_range    (in_range),
        .thr         (thr),
        .sum_ready   (sum_ready),
        .s1_free     (s1_free),
        .sum_valid   (sum_valid),
        .sum_f_cnt   (sum_f_cnt),
        .sum_b_cnt   (sum_b_cnt),
        .sum_f_strip (sum_f_strip),
        .sum_b_strip (sum_b_strip),
        .sum_f_adc   (sum_f_adc),
        .sum_b_adc   (sum_b_adc)
    );

    sshes_qual #(
        .STRIPS (STRIPS)
    ) u_qual (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .sum_valid   (sum_valid),
        .sum_f_cnt   (sum_f_cnt),
        .sum_b_cnt   (sum_b_cnt),
        .sum_f_strip (sum_f_strip),
        .sum_b_strip (sum_b_strip),
        .sum_f_adc   (sum_f_adc),
        .sum_b_adc   (sum_b_adc),
        .sum_ready   (sum_ready),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .hit_pairs   (hit_pairs),
        .front_strip (front_strip),
        .back_strip  (back_strip),
        .front_adc   (front_adc),
        .back_adc    (back_adc),
        .single_hit  (single_hit),
        .accepted    (accepted)
    );

endmodule
